// ----- design/ptp_pkg.sv -----
// Shared constants and types for the point transform with perspective divide.
package ptp_pkg;

	// Fixed-point format: signed Q(31-FRAC_BITS).FRAC_BITS in 32 bits
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	// Column sum magnitude and signed accumulator widths
	localparam int MAG_W     = 64;
	localparam int ACC_W     = 66;
	// One quotient bit per divider stage
	localparam int DIV_STEPS = 32;
	// Matrix registers, two elements each
	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 64;
	localparam int ADDR_W    = 6;

	localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	// Side information that travels with one column through the divider
	typedef struct packed {
		logic num_neg;
		logic den_neg;
		logic num_zero;
		logic den_zero;
	} div_ctl_t;

endpackage

// ----- design/ptp_div.sv -----
// Pipelined restoring divider: one column sum over w, with saturation.
module ptp_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ptp_pkg::MAG_W-1:0]     num_mag,
	input  logic [ptp_pkg::MAG_W-1:0]     den_mag,
	input  ptp_pkg::div_ctl_t             ctl_in,
	output logic [ptp_pkg::DATA_W-1:0]    quo,
	output logic                          sat
);

	localparam int NUM_W = ptp_pkg::MAG_W + ptp_pkg::FRAC_BITS;
	localparam int HI_W  = NUM_W - ptp_pkg::DIV_STEPS;
	localparam int MW    = ptp_pkg::MAG_W;
	localparam int DW    = ptp_pkg::DATA_W;
	localparam int NS    = ptp_pkg::DIV_STEPS;

	// Per-stage pipeline registers
	logic [MW-1:0]          rem_s  [0:NS];
	logic [NS-1:0]          bits_s [0:NS];
	logic [NS-1:0]          quo_s  [0:NS];
	logic [MW-1:0]          den_s  [0:NS];
	logic                   big_s  [0:NS];
	ptp_pkg::div_ctl_t      ctl_s  [0:NS];

	logic [NUM_W-1:0] num_ext;
	logic [HI_W-1:0]  num_hi;

	// Entry: scale numerator, check for a quotient of 2^32 or more
	assign num_ext = {num_mag, {ptp_pkg::FRAC_BITS{1'b0}}};
	assign num_hi  = num_ext[NUM_W-1:NS];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {{(MW-HI_W){1'b0}}, num_hi};
			bits_s[0] <= num_ext[NS-1:0];
			quo_s[0]  <= '0;
			den_s[0]  <= den_mag;
			big_s[0]  <= ({{(MW-HI_W){1'b0}}, num_hi} >= den_mag);
			ctl_s[0]  <= ctl_in;
		end
	end

	// One quotient bit per stage
	for (genvar k = 0; k < NS; k++) begin : g_step
		logic [MW:0]   trial;
		logic [MW+1:0] diff;
		logic          ge;

		assign trial = {rem_s[k], bits_s[k][NS-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_s[k]};
		assign ge    = ~diff[MW+1];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[MW-1:0] : trial[MW-1:0];
				bits_s[k+1] <= {bits_s[k][NS-2:0], 1'b0};
				quo_s[k+1]  <= {quo_s[k][NS-2:0], ge};
				den_s[k+1]  <= den_s[k];
				big_s[k+1]  <= big_s[k];
				ctl_s[k+1]  <= ctl_s[k];
			end
		end
	end

	// Sign, saturation and the zero-w case
	logic          q_neg;
	logic          q_over;
	logic [DW-1:0] q_mag;

	always_comb begin
		q_mag  = quo_s[NS][DW-1:0];
		q_neg  = ctl_s[NS].num_neg ^ ctl_s[NS].den_neg;
		q_over = big_s[NS] ||
			(q_neg ? (q_mag > ptp_pkg::SAT_NEG) : (q_mag > ptp_pkg::SAT_POS));
		if (ctl_s[NS].den_zero) begin
			sat = 1'b0;
			if (ctl_s[NS].num_zero)
				quo = '0;
			else
				quo = ctl_s[NS].num_neg ? ptp_pkg::SAT_NEG : ptp_pkg::SAT_POS;
		end else if (q_over) begin
			sat = 1'b1;
			quo = q_neg ? ptp_pkg::SAT_NEG : ptp_pkg::SAT_POS;
		end else begin
			sat = 1'b0;
			quo = q_neg ? (~q_mag + 1'b1) : q_mag;
		end
	end

endmodule

// ----- design/point_transform_perspective.sv -----
// Top level: 4x4 point transform, perspective divide, output skid stage.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    pos_x, pos_y, pos_z
//   out      output     out_valid / out_stall  out_x, out_y, out_z, w_was_zero, overflowed
//   cfg      input      APB psel/penable       paddr, pwdata, prdata (64-bit matrix registers)
//
// One beat per cycle sustained while in_stall is low; out_valid rises once a beat has passed
// 38 register stages (4 multiply/add stages, divider entry, 32 divider bit stages,
// output register). The divider's one-bit-per-stage chain sets the depth.
// Reset loads the identity matrix and empties the pipeline; no clearing pass.
// A stalled output parks one beat in the skid register, then in_stall rises
// and the whole pipeline holds until the skid drains.
module point_transform_perspective (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input beats
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ptp_pkg::DATA_W-1:0]    pos_x,
	input  logic signed [ptp_pkg::DATA_W-1:0]    pos_y,
	input  logic signed [ptp_pkg::DATA_W-1:0]    pos_z,
	// result beats
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ptp_pkg::DATA_W-1:0]    out_x,
	output logic signed [ptp_pkg::DATA_W-1:0]    out_y,
	output logic signed [ptp_pkg::DATA_W-1:0]    out_z,
	output logic                                 w_was_zero,
	output logic                                 overflowed,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ptp_pkg::ADDR_W-1:0]           paddr,
	input  logic [ptp_pkg::REG_W-1:0]            pwdata,
	output logic [ptp_pkg::REG_W-1:0]            prdata,
	output logic                                 pready
);

	localparam int DW = ptp_pkg::DATA_W;
	localparam int AW = ptp_pkg::ACC_W;
	localparam int MW = ptp_pkg::MAG_W;
	localparam int NS = ptp_pkg::DIV_STEPS;

	// Matrix registers
	logic [ptp_pkg::REG_W-1:0] mat_q [0:ptp_pkg::NUM_REGS-1];
	logic [2:0]                reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign prdata  = mat_q[reg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= 64'h0000_0000_0001_0000;
			mat_q[1] <= 64'h0;
			mat_q[2] <= 64'h0001_0000_0000_0000;
			mat_q[3] <= 64'h0;
			mat_q[4] <= 64'h0;
			mat_q[5] <= 64'h0000_0000_0001_0000;
			mat_q[6] <= 64'h0;
			mat_q[7] <= 64'h0001_0000_0000_0000;
		end else if (psel && penable && pwrite && pready) begin
			mat_q[reg_idx] <= pwdata;
		end
	end

	// Unpack elements
	logic signed [DW-1:0] elem [0:15];
	always_comb begin
		for (int k = 0; k < 16; k++)
			elem[k] = mat_q[k/2][(k%2)*DW +: DW];
	end

	// Pipeline advance: holds only while the skid register is occupied
	logic skid_q;
	logic en;
	assign en       = ~skid_q;
	assign in_stall = skid_q;

	// Stage 1: the twelve products and the translation row
	logic signed [2*DW-1:0] prod_s1 [0:2][0:3];
	logic signed [DW-1:0]   tr_s1   [0:3];
	logic                   v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[0][c] <= pos_x * elem[c];
				prod_s1[1][c] <= pos_y * elem[4+c];
				prod_s1[2][c] <= pos_z * elem[8+c];
				tr_s1[c]      <= elem[12+c];
			end
		end
	end

	// Stage 2: pairwise sums
	logic signed [AW-1:0] a_s2 [0:3];
	logic signed [AW-1:0] b_s2 [0:3];
	logic                 v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				a_s2[c] <= AW'(prod_s1[0][c]) + AW'(prod_s1[1][c]);
				b_s2[c] <= AW'(prod_s1[2][c]) + (AW'(tr_s1[c]) <<< ptp_pkg::FRAC_BITS);
			end
		end
	end

	// Stage 3: column sums
	logic signed [AW-1:0] sum_s3 [0:3];
	logic                 v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++)
				sum_s3[c] <= a_s2[c] + b_s2[c];
		end
	end

	// Stage 4: sign and magnitude
	logic [MW-1:0] mag_s4 [0:3];
	logic          neg_s4 [0:3];
	logic          v_s4;
	logic [AW-1:0] neg_sum [0:3];

	always_comb begin
		for (int c = 0; c < 4; c++)
			neg_sum[c] = -sum_s3[c];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				neg_s4[c] <= sum_s3[c][AW-1];
				mag_s4[c] <= sum_s3[c][AW-1] ? neg_sum[c][MW-1:0] : sum_s3[c][MW-1:0];
			end
		end
	end

	// Valid bits through the multiply stages and the divider
	logic [NS:0] vdiv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			vdiv_s <= '0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			vdiv_s <= {vdiv_s[NS-1:0], v_s4};
		end
	end

	// Three dividers, one per column
	logic [DW-1:0] quo [0:2];
	logic          sat [0:2];
	logic          w_zero;
	logic          w_zero_d;
	ptp_pkg::div_ctl_t ctl [0:2];

	assign w_zero = (mag_s4[3] == '0);

	for (genvar c = 0; c < 3; c++) begin : g_col
		always_comb begin
			ctl[c].num_neg  = neg_s4[c];
			ctl[c].den_neg  = neg_s4[3];
			ctl[c].num_zero = (mag_s4[c] == '0);
			ctl[c].den_zero = w_zero;
		end

		ptp_div u_div (
			.clk     (clk),
			.en      (en),
			.num_mag (mag_s4[c]),
			.den_mag (mag_s4[3]),
			.ctl_in  (ctl[c]),
			.quo     (quo[c]),
			.sat     (sat[c])
		);
	end

	// w zero flag delayed to match the divider
	logic [NS:0] wz_s;
	always_ff @(posedge clk) begin
		if (en)
			wz_s <= {wz_s[NS-1:0], w_zero};
	end
	assign w_zero_d = wz_s[NS];

	// Output register and skid register
	logic                 out_valid_q;
	logic [DW-1:0]        ox_q, oy_q, oz_q, sx_q, sy_q, sz_q;
	logic                 owz_q, oov_q, swz_q, sov_q;
	logic                 load_out, load_skid, skid_to_out, take;
	logic                 new_ov;

	assign new_ov      = sat[0] | sat[1] | sat[2];
	assign take        = out_valid_q & ~out_stall;
	assign skid_to_out = skid_q & ~out_stall;
	assign load_out    = en & vdiv_s[NS] & (~out_valid_q | ~out_stall);
	assign load_skid   = en & vdiv_s[NS] & out_valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_q      <= 1'b0;
		end else begin
			if (skid_to_out)
				skid_q <= 1'b0;
			else if (load_skid)
				skid_q <= 1'b1;
			if (load_out || skid_to_out)
				out_valid_q <= 1'b1;
			else if (take)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_to_out) begin
			ox_q  <= sx_q;
			oy_q  <= sy_q;
			oz_q  <= sz_q;
			owz_q <= swz_q;
			oov_q <= sov_q;
		end else if (load_out) begin
			ox_q  <= quo[0];
			oy_q  <= quo[1];
			oz_q  <= quo[2];
			owz_q <= w_zero_d;
			oov_q <= new_ov;
		end
		if (load_skid) begin
			sx_q  <= quo[0];
			sy_q  <= quo[1];
			sz_q  <= quo[2];
			swz_q <= w_zero_d;
			sov_q <= new_ov;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = ox_q;
	assign out_y      = oy_q;
	assign out_z      = oz_q;
	assign w_was_zero = owz_q;
	assign overflowed = oov_q;

endmodule

// ----- verif/point_transform_perspective_tb.sv -----
// Testbench for point_transform_perspective: matrix transform and perspective divide.
`timescale 1ns / 1ps

module point_transform_perspective_tb;

	localparam int  DATA_W     = ptp_pkg::DATA_W;
	localparam int  ADDR_W     = ptp_pkg::ADDR_W;
	localparam int  REG_W      = ptp_pkg::REG_W;
	localparam int  NUM_REGS   = ptp_pkg::NUM_REGS;
	localparam int  FRAC_BITS  = ptp_pkg::FRAC_BITS;
	localparam logic [DATA_W-1:0] SAT_POS = ptp_pkg::SAT_POS;
	localparam logic [DATA_W-1:0] SAT_NEG = ptp_pkg::SAT_NEG;

	localparam int  CLK_HALF   = 6;
	localparam int  LATENCY    = 37;
	localparam int  SETTLE     = LATENCY + 20;
	localparam int  LONG_HOLD  = 200;
	localparam logic signed [127:0] Q_MAX = 128'sh7FFFFFFF;
	localparam logic signed [127:0] Q_MIN = -128'sh80000000;

	typedef struct packed {
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] z;
		logic              w_zero;
		logic              ovf;
	} proj_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DATA_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] out_x, out_y, out_z;
	logic w_was_zero, overflowed;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [REG_W-1:0] pwdata = '0;
	logic [REG_W-1:0] prdata;
	logic pready;

	// matrix copy kept in step with the block
	logic [REG_W-1:0] mat_shadow [NUM_REGS];
	proj_point_t projected_q [$];
	int  mismatches = 0;
	int  points_sent = 0;
	int  results_seen = 0;
	int  wzero_seen = 0;
	int  ovf_seen = 0;
	bit  send_gaps = 1'b0;
	bit  recv_gaps = 1'b0;
	int  hold_left = 0;

	point_transform_perspective dut (.*);

	always #(CLK_HALF) clk = ~clk;

	initial begin
		#(5_000_000);
		$display("timeout with %0d results outstanding", projected_q.size());
		$display("point_transform_perspective_tb NOT OK");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		mismatches++;
		$display("mismatch %s at result %0d: got %h expected %h", what, results_seen, got, exp);
	endtask

	function automatic logic signed [127:0] mat_elem(input int k);
		logic [REG_W-1:0] r;
		r = mat_shadow[k >> 1];
		return (k & 1) ? 128'(signed'(r[63:32])) : 128'(signed'(r[31:0]));
	endfunction

	// row vector (x, y, z, 1) times the matrix, then x, y, z over w
	function automatic proj_point_t project(input logic signed [DATA_W-1:0] px,
			input logic signed [DATA_W-1:0] py, input logic signed [DATA_W-1:0] pz);
		logic signed [127:0] sum [4];
		logic signed [127:0] q;
		logic [DATA_W-1:0] o [3];
		proj_point_t r;
		r.ovf = 1'b0;
		for (int c = 0; c < 4; c++)
			sum[c] = 128'(px) * mat_elem(c) + 128'(py) * mat_elem(4 + c)
				+ 128'(pz) * mat_elem(8 + c) + (mat_elem(12 + c) <<< FRAC_BITS);
		r.w_zero = (sum[3] == 0);
		for (int c = 0; c < 3; c++) begin
			if (r.w_zero) begin
				o[c] = (sum[c] == 0) ? '0 : (sum[c] < 0) ? SAT_NEG : SAT_POS;
			end else begin
				q = (sum[c] <<< FRAC_BITS) / sum[3];
				if (q > Q_MAX) begin
					o[c] = SAT_POS;
					r.ovf = 1'b1;
				end else if (q < Q_MIN) begin
					o[c] = SAT_NEG;
					r.ovf = 1'b1;
				end else begin
					o[c] = q[DATA_W-1:0];
				end
			end
		end
		r.x = o[0];
		r.y = o[1];
		r.z = o[2];
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		proj_point_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (projected_q.size() == 0) begin
				report("unexpected beat", {out_x, out_y}, '0);
			end else begin
				e = projected_q.pop_front();
				if (out_x !== e.x) report("out_x", out_x, e.x);
				if (out_y !== e.y) report("out_y", out_y, e.y);
				if (out_z !== e.z) report("out_z", out_z, e.z);
				if (w_was_zero !== e.w_zero) report("w_was_zero", w_was_zero, e.w_zero);
				if (overflowed !== e.ovf) report("overflowed", overflowed, e.ovf);
				wzero_seen += e.w_zero;
				ovf_seen += e.ovf;
			end
		end
	end

	// receiver: random stall bursts, plus an occasional long hold-off
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (burst > 0) begin
				out_stall = 1'b1;
				burst--;
			end else begin
				out_stall = 1'b0;
				if (recv_gaps && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 9);
			end
		end
	end

	task automatic send_point(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
			input logic [DATA_W-1:0] z);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid = 1'b1;
		pos_x = x;
		pos_y = y;
		pos_z = z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		projected_q.push_back(project(x, y, z));
		points_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		wait (projected_q.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_write(input int idx, input logic [REG_W-1:0] val);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = ADDR_W'(8 * idx);
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		mat_shadow[idx] = val;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apb_check(input int idx);
		psel = 1'b1;
		pwrite = 1'b0;
		paddr = ADDR_W'(8 * idx);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== mat_shadow[idx]) report("register readback", prdata, mat_shadow[idx]);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] rand_value(input bit wide_ok);
		case ($urandom_range(0, wide_ok ? 9 : 7))
			0:       return '0;
			1:       return SAT_POS;
			2:       return SAT_NEG;
			3, 4, 5: return DATA_W'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
			6, 7:    return DATA_W'($signed($urandom_range(0, 512 << FRAC_BITS)) - (256 << FRAC_BITS));
			default: return $urandom();
		endcase
	endfunction

	task automatic load_matrix(input logic [DATA_W-1:0] e [16]);
		for (int i = 0; i < NUM_REGS; i++) apb_write(i, {e[2*i+1], e[2*i]});
	endtask

	task automatic load_random_matrix(input bit w_const_zero);
		logic [DATA_W-1:0] e [16];
		for (int k = 0; k < 16; k++) e[k] = rand_value(1'b1);
		// keep w a nonzero constant most of the time so the divide stays in range
		if (w_const_zero) begin
			e[3] = '0; e[7] = '0; e[11] = '0; e[15] = '0;
		end else if ($urandom_range(0, 2) != 0) begin
			e[3] = '0; e[7] = '0; e[11] = '0;
			e[15] = DATA_W'($urandom_range(1, 4 << FRAC_BITS));
		end
		load_matrix(e);
	endtask

	task automatic test_reset_identity();
		logic [DATA_W-1:0] ext [8];
		ext = '{'0, 32'h1, 32'hFFFFFFFF, SAT_POS, SAT_NEG, 32'h00010000, 32'hFFFF0000, 32'h55AAAA55};
		for (int i = 0; i < NUM_REGS; i++) apb_check(i);
		for (int i = 0; i < 8; i++)
			send_point(ext[i], ext[(i + 3) % 8], ext[(i + 5) % 8]);
		drain();
	endtask

	task automatic test_special_cases();
		logic [DATA_W-1:0] e [16];
		// zero w: each output saturates by its own numerator sign, or is zero for a zero numerator
		e = '{default: '0};
		e[0] = 32'h00010000;
		e[5] = 32'hFFFF0000;
		load_matrix(e);
		send_point(32'h00020000, 32'h00030000, 32'h12345678);
		send_point(32'hFFFE0000, 32'hFFFD0000, '0);
		send_point('0, '0, '0);
		drain();
		// quotient out of range: huge numerator over a tiny w
		e = '{default: '0};
		e[0] = SAT_POS; e[5] = SAT_NEG; e[10] = 32'h00010000;
		e[15] = 32'h00000001;
		load_matrix(e);
		send_point(SAT_POS, SAT_POS, 32'h00010000);
		send_point(SAT_NEG, SAT_NEG, SAT_NEG);
		send_point(32'h00000001, 32'hFFFFFFFF, '0);
		drain();
		// negative w flips signs
		e[15] = 32'hFFFF0000;
		e[0] = 32'h00010000; e[5] = 32'h00010000;
		apb_write(0, {e[1], e[0]});
		apb_write(2, {e[5], e[4]});
		apb_write(7, {e[15], e[14]});
		apb_check(7);
		send_point(32'h00030000, 32'hFFFD0000, 32'h00008000);
		send_point(32'h80000000, 32'h7FFFFFFF, 32'h00000001);
		drain();
		// all elements at each extreme
		for (int m = 0; m < 2; m++) begin
			e = '{default: (m == 0) ? SAT_POS : SAT_NEG};
			load_matrix(e);
			send_point(SAT_POS, SAT_NEG, 32'h00010000);
			send_point(32'h00000001, 32'h00000002, 32'h00000003);
			drain();
		end
	endtask

	task automatic test_random_phases(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			load_random_matrix(p % 7 == 3);
			for (int i = 0; i < per_phase; i++)
				send_point(rand_value(1'b1), rand_value(1'b1), rand_value(1'b1));
			drain();
		end
	endtask

	task automatic test_backpressure();
		load_random_matrix(1'b0);
		@(negedge clk);
		hold_left = LONG_HOLD;
		for (int i = 0; i < 90; i++)
			send_point(rand_value(1'b1), rand_value(1'b1), rand_value(1'b1));
		drain();
	endtask

	task automatic test_sender_pause();
		for (int i = 0; i < 12; i++)
			send_point(rand_value(1'b0), rand_value(1'b0), rand_value(1'b0));
		in_valid = 1'b0;
		wait (projected_q.size() == 0);
		@(negedge clk);
		for (int i = 0; i < 12; i++)
			send_point(rand_value(1'b0), rand_value(1'b0), rand_value(1'b0));
		drain();
	endtask

	initial begin
		for (int i = 0; i < NUM_REGS; i++) mat_shadow[i] = '0;
		mat_shadow[0] = 64'h0000000000010000;
		mat_shadow[2] = 64'h0001000000000000;
		mat_shadow[5] = 64'h0000000000010000;
		mat_shadow[7] = 64'h0001000000000000;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_identity();
		test_special_cases();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		test_random_phases(12, 110);
		test_backpressure();
		test_sender_pause();
		// closing stretch with no idling on either side
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		test_random_phases(2, 80);

		$display("covered %0d points under %0d-register matrices, stalls and gaps on both sides",
			points_sent, NUM_REGS);
		$display("results %0d, zero-w %0d, saturated %0d", results_seen, wzero_seen, ovf_seen);
		if (mismatches == 0 && projected_q.size() == 0) begin
			$display("point_transform_perspective_tb OK");
		end else begin
			$display("point_transform_perspective_tb NOT OK");
		end
		$finish;
	end

endmodule

// ----- point_transform_perspective.f -----
design/ptp_pkg.sv
design/ptp_div.sv
design/point_transform_perspective.sv
verif/point_transform_perspective_tb.sv
